FILE: rtl/btf_pkg.sv
// btf_pkg: widths, constants, forecast codes and stage request types
// for the barometric trend forecaster; no dependencies
package btf_pkg;

    localparam int PRESS_W     = 11;
    localparam int SUM_W       = 14;
    localparam int MAG_W       = 14;
    localparam int THR_W       = 4;
    localparam int FC_W        = 3;
    localparam int SLOPE_W     = 26;
    localparam int HALF_W      = 4;
    localparam int MIN_W       = 8;
    localparam int RECIP_W     = 44;
    localparam int RECIP_SHIFT = 30;
    localparam int PROD_W      = MAG_W + RECIP_W;
    localparam int QUO_W       = PROD_W - RECIP_SHIFT;
    localparam int NUM_END     = 5;

    localparam logic [MIN_W-1:0] WIN_END [NUM_END] = '{8'd35, 8'd60, 8'd95, 8'd120, 8'd155};
    localparam logic [MIN_W-1:0] FIRST_KNOWN_MINUTE = 8'd35;

    // slope = 130 * 65536 * diff / (1023 * window_len * half_hours)
    localparam longint unsigned SLOPE_NUM      = 64'd8519680;
    localparam longint unsigned SLOPE_DEN_BASE = 64'd1023;

    localparam logic [QUO_W-1:0] SLOPE_MAG_MAX = 28'd33554431;

    localparam logic signed [SLOPE_W-1:0] FAST_LIMIT   = 26'sd16384;
    localparam logic signed [SLOPE_W-1:0] SLOW_LIMIT   = 26'sd3277;
    localparam logic signed [SLOPE_W-1:0] STABLE_LIMIT = 26'sd3276;

    localparam logic [FC_W-1:0] FC_STABLE    = 3'd0;
    localparam logic [FC_W-1:0] FC_SLOW_RISE = 3'd1;
    localparam logic [FC_W-1:0] FC_SLOW_FALL = 3'd2;
    localparam logic [FC_W-1:0] FC_FAST_RISE = 3'd3;
    localparam logic [FC_W-1:0] FC_FAST_FALL = 3'd4;
    localparam logic [FC_W-1:0] FC_UNKNOWN   = 3'd5;
    localparam logic [FC_W-1:0] FC_NONE      = 3'd7;

    typedef struct packed {
        logic               neg;
        logic [MAG_W-1:0]   mag;
        logic [HALF_W-1:0]  half;
        logic               unknown;
        logic [PRESS_W-1:0] pressure;
        logic               force_report;
    } t_win_req;

    typedef struct packed {
        logic               neg;
        logic [QUO_W-1:0]   quo;
        logic               load;
        logic               unknown;
        logic [PRESS_W-1:0] pressure;
        logic               force_report;
    } t_slope_req;

endpackage

FILE: rtl/baro_trend_forecast_core.sv
// baro_trend_forecast_core: top level of the barometric trend forecaster
// depends on btf_pkg, btf_window, btf_slope and btf_decide
//
// One pressure sample per request gives one result: forecast code, signed
// trend (16 fraction bits) and the two report flags. The block is a four-deep
// pipeline (input register, window stage, slope multiply stage, decision and
// result register), and a new request is taken every cycle that o_stall is
// low. Empty stages let requests keep flowing while a result waits at the
// output; stall is raised only when all four stages hold requests. The slope
// uses one 14 x 44 bit multiply by a reciprocal chosen by the elapsed half
// hours. The report threshold may be written whenever no request is in
// flight.
module baro_trend_forecast_core #(
    parameter int CYCLE_MINUTES = 180,
    parameter int WINDOW_LEN    = 5
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [btf_pkg::PRESS_W-1:0]        i_pressure_hpa,
    input  logic                               i_force_report,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [btf_pkg::FC_W-1:0]           o_forecast,
    output logic signed [btf_pkg::SLOPE_W-1:0] o_slope,
    output logic                               o_report_pressure,
    output logic                               o_report_forecast,
    input  logic                               i_cfg_we,
    input  logic [btf_pkg::THR_W-1:0]          i_cfg_wdata
);
    import btf_pkg::*;

    logic               r_v_in, r_v_win, r_v_slope, r_v_out;
    logic [PRESS_W-1:0] r_in_pressure;
    logic               r_in_force;
    logic [THR_W-1:0]   r_report_threshold;

    logic rdy_out, rdy_slope, rdy_win, rdy_in;
    logic adv_win, adv_slope, adv_out, accept;

    t_win_req   win_req;
    t_slope_req slope_req;

    assign rdy_out   = !r_v_out || !i_stall;
    assign adv_out   = r_v_slope && rdy_out;
    assign rdy_slope = !r_v_slope || rdy_out;
    assign adv_slope = r_v_win && rdy_slope;
    assign rdy_win   = !r_v_win || rdy_slope;
    assign adv_win   = r_v_in && rdy_win;
    assign rdy_in    = !r_v_in || rdy_win;
    assign accept    = i_valid && rdy_in;

    assign o_stall = !rdy_in;
    assign o_valid = r_v_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_in             <= 1'b0;
            r_v_win            <= 1'b0;
            r_v_slope          <= 1'b0;
            r_v_out            <= 1'b0;
            r_report_threshold <= '0;
        end else begin
            r_v_in    <= accept || (r_v_in && !adv_win);
            r_v_win   <= adv_win || (r_v_win && !adv_slope);
            r_v_slope <= adv_slope || (r_v_slope && !adv_out);
            r_v_out   <= adv_out || (r_v_out && i_stall);
            if (i_cfg_we) begin
                r_report_threshold <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_pressure <= i_pressure_hpa;
            r_in_force    <= i_force_report;
        end
    end

    btf_window #(
        .CYCLE_MINUTES (CYCLE_MINUTES),
        .WINDOW_LEN    (WINDOW_LEN)
    ) u_window (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (adv_win),
        .i_pressure_hpa (r_in_pressure),
        .i_force_report (r_in_force),
        .o_req          (win_req)
    );

    btf_slope #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_slope (
        .i_clk (i_clk),
        .i_adv (adv_slope),
        .i_req (win_req),
        .o_req (slope_req)
    );

    btf_decide u_decide (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_adv              (adv_out),
        .i_req              (slope_req),
        .i_report_threshold (r_report_threshold),
        .o_forecast         (o_forecast),
        .o_slope            (o_slope),
        .o_report_pressure  (o_report_pressure),
        .o_report_forecast  (o_report_forecast)
    );

endmodule

FILE: rtl/btf_window.sv
// btf_window: minute counter, window sums, baseline and hold sums
// depends on btf_pkg; feeds the slope stage with a t_win_req
module btf_window #(
    parameter int CYCLE_MINUTES = 180,
    parameter int WINDOW_LEN    = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic [btf_pkg::PRESS_W-1:0]  i_pressure_hpa,
    input  logic                         i_force_report,
    output btf_pkg::t_win_req            o_req
);
    import btf_pkg::*;

    localparam logic [MIN_W-1:0] CYC        = MIN_W'(CYCLE_MINUTES);
    localparam logic [MIN_W-1:0] WIN        = MIN_W'(WINDOW_LEN);
    localparam logic [MIN_W-1:0] WRAP_START = MIN_W'(CYCLE_MINUTES + 1 - WINDOW_LEN);

    logic [MIN_W-1:0]   r_minute,       n_minute;
    logic               r_first_round,  n_first_round;
    logic [SUM_W-1:0]   r_window_sum,   n_window_sum;
    logic [SUM_W-1:0]   r_baseline_sum, n_baseline_sum;
    logic [SUM_W-1:0]   r_hold_sum,     n_hold_sum;
    t_win_req           r_req,          n_req;

    logic [MIN_W-1:0]   base;
    logic               start;
    logic [HALF_W-1:0]  half;
    logic               hold_now;
    logic               cycle_end;
    logic [SUM_W:0]     diff;

    always_comb begin
        base     = (r_minute >= CYC) ? WIN : r_minute;
        n_minute = base + 8'd1;

        start = (n_minute == 8'd1) || (n_minute == WRAP_START);
        for (int k = 0; k < NUM_END; k++) begin
            if (n_minute == WIN_END[k] + 8'd1 - WIN) begin
                start = 1'b1;
            end
        end
        n_window_sum = start ? SUM_W'(i_pressure_hpa)
                             : r_window_sum + SUM_W'(i_pressure_hpa);

        half     = '0;
        hold_now = 1'b0;
        for (int k = NUM_END - 1; k >= 0; k--) begin
            if (n_minute == WIN_END[k]) begin
                half     = HALF_W'(k + 1);
                hold_now = (k == NUM_END - 1);
            end
        end
        cycle_end = 1'b0;
        if (half == '0 && n_minute == CYC) begin
            half      = HALF_W'(NUM_END + 1);
            cycle_end = 1'b1;
        end
        if (n_minute == WIN) begin
            half      = '0;
            hold_now  = 1'b0;
            cycle_end = 1'b0;
        end
        if (!r_first_round && half != '0) begin
            half = half + 4'd2;
        end

        n_baseline_sum = r_baseline_sum;
        n_hold_sum     = r_hold_sum;
        n_first_round  = r_first_round;
        if (n_minute == WIN) begin
            n_baseline_sum = n_window_sum;
        end
        if (hold_now) begin
            n_hold_sum = n_window_sum;
        end
        if (cycle_end) begin
            n_baseline_sum = r_hold_sum;
            n_first_round  = 1'b0;
        end

        // slope uses the baseline from before this sample
        diff = {1'b0, n_window_sum} - {1'b0, r_baseline_sum};

        n_req.neg          = diff[SUM_W];
        n_req.mag          = diff[SUM_W] ? MAG_W'(-diff) : diff[MAG_W-1:0];
        n_req.half         = half;
        n_req.unknown      = r_first_round && (n_minute < FIRST_KNOWN_MINUTE);
        n_req.pressure     = i_pressure_hpa;
        n_req.force_report = i_force_report;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_minute       <= '0;
            r_first_round  <= 1'b1;
            r_window_sum   <= '0;
            r_baseline_sum <= '0;
            r_hold_sum     <= '0;
        end else if (i_adv) begin
            r_minute       <= n_minute;
            r_first_round  <= n_first_round;
            r_window_sum   <= n_window_sum;
            r_baseline_sum <= n_baseline_sum;
            r_hold_sum     <= n_hold_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_req <= n_req;
        end
    end

    assign o_req = r_req;

endmodule

FILE: rtl/btf_slope.sv
// btf_slope: scales the window difference by a per-interval reciprocal
// depends on btf_pkg; takes a t_win_req, gives a t_slope_req
module btf_slope #(
    parameter int WINDOW_LEN = 5
) (
    input  logic                 i_clk,
    input  logic                 i_adv,
    input  btf_pkg::t_win_req    i_req,
    output btf_pkg::t_slope_req  o_req
);
    import btf_pkg::*;

    localparam longint unsigned SCALED = SLOPE_NUM << RECIP_SHIFT;
    localparam longint unsigned DEN_1  = SLOPE_DEN_BASE * 64'(WINDOW_LEN) * 64'd1;
    localparam longint unsigned DEN_2  = SLOPE_DEN_BASE * 64'(WINDOW_LEN) * 64'd2;
    localparam longint unsigned DEN_3  = SLOPE_DEN_BASE * 64'(WINDOW_LEN) * 64'd3;
    localparam longint unsigned DEN_4  = SLOPE_DEN_BASE * 64'(WINDOW_LEN) * 64'd4;
    localparam longint unsigned DEN_5  = SLOPE_DEN_BASE * 64'(WINDOW_LEN) * 64'd5;
    localparam longint unsigned DEN_6  = SLOPE_DEN_BASE * 64'(WINDOW_LEN) * 64'd6;
    localparam longint unsigned DEN_7  = SLOPE_DEN_BASE * 64'(WINDOW_LEN) * 64'd7;
    localparam longint unsigned DEN_8  = SLOPE_DEN_BASE * 64'(WINDOW_LEN) * 64'd8;

    // rounded-up reciprocals, exact for any 14-bit magnitude
    localparam logic [RECIP_W-1:0] RECIP_1 = RECIP_W'((SCALED + DEN_1 - 64'd1) / DEN_1);
    localparam logic [RECIP_W-1:0] RECIP_2 = RECIP_W'((SCALED + DEN_2 - 64'd1) / DEN_2);
    localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'((SCALED + DEN_3 - 64'd1) / DEN_3);
    localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'((SCALED + DEN_4 - 64'd1) / DEN_4);
    localparam logic [RECIP_W-1:0] RECIP_5 = RECIP_W'((SCALED + DEN_5 - 64'd1) / DEN_5);
    localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'((SCALED + DEN_6 - 64'd1) / DEN_6);
    localparam logic [RECIP_W-1:0] RECIP_7 = RECIP_W'((SCALED + DEN_7 - 64'd1) / DEN_7);
    localparam logic [RECIP_W-1:0] RECIP_8 = RECIP_W'((SCALED + DEN_8 - 64'd1) / DEN_8);

    logic [RECIP_W-1:0] recip;
    logic [PROD_W-1:0]  prod;
    t_slope_req         r_req;
    t_slope_req         n_req;

    always_comb begin
        case (i_req.half)
            4'd1:    recip = RECIP_1;
            4'd2:    recip = RECIP_2;
            4'd3:    recip = RECIP_3;
            4'd4:    recip = RECIP_4;
            4'd5:    recip = RECIP_5;
            4'd6:    recip = RECIP_6;
            4'd7:    recip = RECIP_7;
            4'd8:    recip = RECIP_8;
            default: recip = '0;
        endcase
        prod = PROD_W'(i_req.mag) * PROD_W'(recip);

        n_req.neg          = i_req.neg;
        n_req.quo          = prod[PROD_W-1:RECIP_SHIFT];
        n_req.load         = (i_req.half != '0);
        n_req.unknown      = i_req.unknown;
        n_req.pressure     = i_req.pressure;
        n_req.force_report = i_req.force_report;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_req <= n_req;
        end
    end

    assign o_req = r_req;

endmodule

FILE: rtl/btf_decide.sv
// btf_decide: trend register, forecast decision and report flags
// depends on btf_pkg; takes a t_slope_req, drives the result register
module btf_decide (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  btf_pkg::t_slope_req               i_req,
    input  logic [btf_pkg::THR_W-1:0]         i_report_threshold,
    output logic [btf_pkg::FC_W-1:0]          o_forecast,
    output logic signed [btf_pkg::SLOPE_W-1:0] o_slope,
    output logic                              o_report_pressure,
    output logic                              o_report_forecast
);
    import btf_pkg::*;

    logic signed [SLOPE_W-1:0] r_trend, n_trend;
    logic [PRESS_W-1:0]        r_last_pressure, n_last_pressure;
    logic [FC_W-1:0]           r_last_forecast, n_last_forecast;

    logic [FC_W-1:0]           r_forecast;
    logic signed [SLOPE_W-1:0] r_slope;
    logic                      r_report_pressure;
    logic                      r_report_forecast;

    logic [QUO_W-1:0]          mag_sat;
    logic signed [SLOPE_W-1:0] mag_s;
    logic [FC_W-1:0]           fc;
    logic [PRESS_W-1:0]        delta;
    logic                      rep_p;
    logic                      rep_f;

    always_comb begin
        mag_sat = (i_req.quo > SLOPE_MAG_MAX) ? SLOPE_MAG_MAX : i_req.quo;
        mag_s   = $signed(mag_sat[SLOPE_W-1:0]);
        n_trend = r_trend;
        if (i_req.load) begin
            n_trend = i_req.neg ? -mag_s : mag_s;
        end

        if (i_req.unknown) begin
            fc = FC_UNKNOWN;
        end else if (n_trend < -FAST_LIMIT) begin
            fc = FC_FAST_FALL;
        end else if (n_trend > FAST_LIMIT) begin
            fc = FC_FAST_RISE;
        end else if (n_trend > -FAST_LIMIT && n_trend <= -SLOW_LIMIT) begin
            fc = FC_SLOW_FALL;
        end else if (n_trend >= SLOW_LIMIT && n_trend < FAST_LIMIT) begin
            fc = FC_SLOW_RISE;
        end else if (n_trend >= -STABLE_LIMIT && n_trend <= STABLE_LIMIT) begin
            fc = FC_STABLE;
        end else begin
            // exact tie on the fast limit
            fc = FC_UNKNOWN;
        end

        delta = (i_req.pressure > r_last_pressure) ? i_req.pressure - r_last_pressure
                                                   : r_last_pressure - i_req.pressure;
        rep_p = i_req.force_report || (delta > PRESS_W'(i_report_threshold));
        rep_f = i_req.force_report || (fc != r_last_forecast);

        n_last_pressure = rep_p ? i_req.pressure : r_last_pressure;
        n_last_forecast = rep_f ? fc : r_last_forecast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trend         <= '0;
            r_last_pressure <= '0;
            r_last_forecast <= FC_NONE;
        end else if (i_adv) begin
            r_trend         <= n_trend;
            r_last_pressure <= n_last_pressure;
            r_last_forecast <= n_last_forecast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_forecast        <= fc;
            r_slope           <= n_trend;
            r_report_pressure <= rep_p;
            r_report_forecast <= rep_f;
        end
    end

    assign o_forecast        = r_forecast;
    assign o_slope           = r_slope;
    assign o_report_pressure = r_report_pressure;
    assign o_report_forecast = r_report_forecast;

endmodule

FILE: tb/sv/baro_trend_forecast_core_test.sv
// baro_trend_forecast_core_test: self-checking bench for the barometric trend forecaster
// keeps its own forecaster state and checks every result in order against it
// depends on btf_pkg and baro_trend_forecast_core
`timescale 1ns / 100ps

module baro_trend_forecast_core_test;
    import btf_pkg::*;

    localparam int CYCLE_LEN      = 180;
    localparam int WIN_LEN        = 5;
    localparam int PIPE_DEPTH     = 4;
    localparam int SAMPLE_TARGET  = 550;
    localparam int CFG_SPACING    = 100;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [FC_W-1:0]           code;
        logic signed [SLOPE_W-1:0] slope;
        logic                      rep_press;
        logic                      rep_fc;
    } t_baro_result;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic [PRESS_W-1:0]        i_pressure_hpa;
    logic                      i_force_report;
    logic                      o_valid;
    logic                      i_stall;
    logic [FC_W-1:0]           o_forecast;
    logic signed [SLOPE_W-1:0] o_slope;
    logic                      o_report_pressure;
    logic                      o_report_forecast;
    logic                      i_cfg_we;
    logic [THR_W-1:0]          i_cfg_wdata;

    // forecaster state mirrored by the bench
    int                        minute_ctr     = 0;
    bit                        in_first_round = 1'b1;
    logic [SUM_W-1:0]          win_acc        = '0;
    logic [SUM_W-1:0]          base_acc       = '0;
    logic [SUM_W-1:0]          held_acc       = '0;
    logic signed [SLOPE_W-1:0] trend_val      = '0;
    logic [PRESS_W-1:0]        last_press     = '0;
    logic [FC_W-1:0]           last_code      = FC_NONE;
    logic [THR_W-1:0]          thr_reg        = '0;

    t_baro_result pending_forecasts[$];
    int err_cnt      = 0;
    int n_sent       = 0;
    int n_results    = 0;
    int n_cfg        = 0;
    int idle_cycles  = 0;
    int hold_left    = 0;
    bit quiet_send   = 1'b0;
    bit rx_stalls    = 1'b1;
    int code_hits[8] = '{default: 0};

    baro_trend_forecast_core #(
        .CYCLE_MINUTES(CYCLE_LEN),
        .WINDOW_LEN(WIN_LEN)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_pressure_hpa(i_pressure_hpa),
        .i_force_report(i_force_report),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_forecast(o_forecast),
        .o_slope(o_slope),
        .o_report_pressure(o_report_pressure),
        .o_report_forecast(o_report_forecast),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic signed [SLOPE_W-1:0] trend_for(input int half);
        longint diff;
        longint mag;
        longint q;
        diff = longint'(win_acc) - longint'(base_acc);
        mag  = (diff < 0) ? -diff : diff;
        q    = (mag * 130 * 65536) / (1023 * WIN_LEN * half);
        if (q > 33554431) q = 33554431;
        return (diff < 0) ? SLOPE_W'(-q) : SLOPE_W'(q);
    endfunction

    function automatic logic [FC_W-1:0] forecast_code(input int minute);
        int t;
        t = trend_val;
        if (in_first_round && minute < FIRST_KNOWN_MINUTE) return FC_UNKNOWN;
        if (t < -FAST_LIMIT) return FC_FAST_FALL;
        if (t > FAST_LIMIT) return FC_FAST_RISE;
        if (t > -FAST_LIMIT && t <= -SLOW_LIMIT) return FC_SLOW_FALL;
        if (t >= SLOW_LIMIT && t < FAST_LIMIT) return FC_SLOW_RISE;
        if (t >= -STABLE_LIMIT && t <= STABLE_LIMIT) return FC_STABLE;
        return FC_UNKNOWN;
    endfunction

    function automatic t_baro_result predict_forecast(input logic [PRESS_W-1:0] p,
                                                      input logic f);
        t_baro_result res;
        int c;
        int half;
        int d;
        bit restart;
        bit hold_now;
        bit cyc_end;
        half     = 0;
        hold_now = 1'b0;
        cyc_end  = 1'b0;
        if (minute_ctr >= CYCLE_LEN) minute_ctr = WIN_LEN;
        c = minute_ctr + 1;
        minute_ctr = c;

        restart = (c == 1) || (c + WIN_LEN == CYCLE_LEN + 1);
        for (int k = 0; k < NUM_END; k++) begin
            if (c + WIN_LEN == int'(WIN_END[k]) + 1) restart = 1'b1;
        end
        win_acc = restart ? SUM_W'(p) : win_acc + SUM_W'(p);

        if (c == WIN_LEN) begin
            base_acc = win_acc;
        end else begin
            for (int k = 0; k < NUM_END; k++) begin
                if (half == 0 && c == int'(WIN_END[k])) begin
                    half     = k + 1;
                    hold_now = (k == NUM_END - 1);
                end
            end
            if (half == 0 && c == CYCLE_LEN) begin
                half    = 6;
                cyc_end = 1'b1;
            end
            if (half != 0) begin
                if (!in_first_round) half += 2;
                trend_val = trend_for(half);
                if (hold_now) held_acc = win_acc;
                if (cyc_end) begin
                    base_acc       = held_acc;
                    in_first_round = 1'b0;
                end
            end
        end

        res.code  = forecast_code(c);
        res.slope = trend_val;
        d = (p > last_press) ? int'(p) - int'(last_press) : int'(last_press) - int'(p);
        res.rep_press = f || (d > thr_reg);
        if (res.rep_press) last_press = p;
        res.rep_fc = f || (res.code != last_code);
        if (res.rep_fc) last_code = res.code;
        return res;
    endfunction

    task automatic send_sample(input logic [PRESS_W-1:0] p, input logic f);
        int gap;
        gap = quiet_send ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_pressure_hpa <= p;
        i_force_report <= f;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_forecasts.push_back(predict_forecast(p, f));
        n_sent++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_forecasts.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        thr_reg = v;
        n_cfg++;
    endtask

    // widest threshold, both pressure extremes, forced and unforced reports
    task automatic test_report_extremes();
        write_threshold(4'd15);
        send_sample(11'd0, 1'b0);
        send_sample(11'd2047, 1'b0);
        send_sample(11'd2047, 1'b1);
        send_sample(11'd2032, 1'b0);
        send_sample(11'd2031, 1'b0);
        send_sample(11'd0, 1'b1);
        drain_results();
    endtask

    // zero threshold: any change reports, no change does not
    task automatic test_threshold_zero();
        write_threshold(4'd0);
        send_sample(11'd0, 1'b0);
        send_sample(11'd1, 1'b0);
        send_sample(11'd1, 1'b0);
        send_sample(11'd1024, 1'b1);
        send_sample(11'd1023, 1'b0);
        send_sample(11'd2047, 1'b0);
        send_sample(11'd0, 1'b0);
        drain_results();
    endtask

    // receiver holds off while requests keep coming, then all drain
    task automatic test_output_backpressure();
        write_threshold(4'd7);
        quiet_send = 1'b1;
        hold_left  = 40;
        repeat (12) send_sample(11'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)));
        quiet_send = 1'b0;
        drain_results();
    endtask

    task automatic run_segment(input int len);
        int kind;
        int base;
        int num;
        int den;
        int v;
        kind = $urandom_range(0, 9);
        base = $urandom_range(0, 2047);
        num  = int'($urandom_range(0, 8)) - 4;
        den  = $urandom_range(1, 80);
        for (int i = 0; i < len; i++) begin
            if (kind < 6) v = base + (i * num) / den;
            else if (kind < 9) v = base + int'($urandom_range(0, 2)) - 1;
            else v = $urandom_range(0, 2047);
            if (v < 0) v = 0;
            if (v > 2047) v = 2047;
            send_sample(v[PRESS_W-1:0], $urandom_range(0, 7) == 0);
        end
    endtask

    // ramps, plateaus and noise over several full cycles
    task automatic test_trend_segments();
        int next_cfg;
        int pick;
        int len;
        next_cfg = n_sent + CFG_SPACING;
        while (n_sent < SAMPLE_TARGET) begin
            quiet_send = ($urandom_range(0, 3) == 0);
            rx_stalls  = ($urandom_range(0, 3) != 0);
            len = $urandom_range(20, 120);
            if (len > SAMPLE_TARGET - n_sent) len = SAMPLE_TARGET - n_sent;
            run_segment(len);
            if (n_sent >= next_cfg) begin
                drain_results();
                pick = $urandom_range(0, 2);
                if (pick == 0) write_threshold(4'd0);
                else if (pick == 1) write_threshold(4'd15);
                else write_threshold(THR_W'($urandom_range(0, 15)));
                next_cfg += CFG_SPACING;
            end
        end
        quiet_send = 1'b0;
        rx_stalls  = 1'b1;
    endtask

    // receiver side
    initial begin
        int stall_left;
        stall_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
                if (rx_stalls && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        t_baro_result want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            n_results++;
            if (pending_forecasts.size() == 0) begin
                $error("result with no pending request: forecast %0d slope %0d",
                       o_forecast, o_slope);
                err_cnt++;
            end else begin
                want = pending_forecasts.pop_front();
                code_hits[want.code]++;
                if (o_forecast !== want.code) begin
                    $error("forecast: expected %0d, got %0d", want.code, o_forecast);
                    err_cnt++;
                end
                if (o_slope !== want.slope) begin
                    $error("slope: expected %0d, got %0d", want.slope, o_slope);
                    err_cnt++;
                end
                if (o_report_pressure !== want.rep_press) begin
                    $error("report_pressure: expected %0b, got %0b",
                           want.rep_press, o_report_pressure);
                    err_cnt++;
                end
                if (o_report_forecast !== want.rep_fc) begin
                    $error("report_forecast: expected %0b, got %0b",
                           want.rep_fc, o_report_forecast);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid === 1'b1 && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no request moved for %0d cycles", idle_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_pressure_hpa <= '0;
        i_force_report <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_report_extremes();
        test_threshold_zero();
        test_output_backpressure();
        test_trend_segments();

        drain_results();
        repeat (2 * PIPE_DEPTH) @(posedge i_clk);
        $display("run covered %0d samples, %0d results checked, %0d threshold writes",
                 n_sent, n_results, n_cfg);
        $display("forecasts: stable %0d, slow rise %0d, slow fall %0d, %s%0d, %s%0d, %s%0d",
                 code_hits[FC_STABLE], code_hits[FC_SLOW_RISE], code_hits[FC_SLOW_FALL],
                 "fast rise ", code_hits[FC_FAST_RISE], "fast fall ",
                 code_hits[FC_FAST_FALL], "unknown ", code_hits[FC_UNKNOWN]);
        if (err_cnt == 0 && pending_forecasts.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
